FILE: rtl/core/fpd_pkg.sv
package fpd_pkg;

  // Window geometry: one sample plus four of padding on either side.
  localparam int PAD_SAMPLES = 4;
  localparam int WIN_DEPTH   = PAD_SAMPLES + 1;
  localparam int WARM_W      = $clog2(WIN_DEPTH + 1);
  localparam int PAD_W       = $clog2(PAD_SAMPLES + 1);

  // Fixed field widths.
  localparam int VEL_W  = 48;
  localparam int ACC_W  = 64;
  localparam int RATE_W = 11;
  localparam logic [RATE_W-1:0] RATE_RESET = 11'd100;

  // Stencil arithmetic: the difference sum is at most 18 times a 48-bit input.
  localparam int DIFF_W = VEL_W + 5;
  localparam int MAG_W  = 64;

  localparam logic signed [ACC_W-1:0] VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] VEL_MIN = -(64'sd1 <<< (VEL_W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_VEL_GO,
    S_VEL_WAIT,
    S_ACC_GO,
    S_ACC_WAIT,
    S_OUT,
    S_NEXT
  } fpd_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_DIV,
    ST_DONE
  } st_state_e;

  typedef struct packed {
    logic fill;
    logic pos_shift;
    logic vel_shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } st_stat_t;

endpackage

FILE: rtl/core/fpd_cell.sv
module fpd_cell import fpd_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] pos_new_i,
  input  logic signed [SAMPLE_BITS-1:0] pos_nb_i,
  input  logic signed [VEL_W-1:0]       vel_nb_i,
  output logic signed [SAMPLE_BITS-1:0] pos_o,
  output logic signed [VEL_W-1:0]       vel_o
);

  logic signed [SAMPLE_BITS-1:0] pos_q, pos_d;
  logic signed [VEL_W-1:0]       vel_q, vel_d;

  // fill loads the fresh sample, shift takes the younger neighbour's value
  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.fill) begin
      pos_d = pos_new_i;
    end else if (ctrl_i.pos_shift) begin
      pos_d = pos_nb_i;
    end
    vel_d = ctrl_i.vel_shift ? vel_nb_i : vel_q;
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    vel_q <= vel_d;
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;

endmodule

FILE: rtl/core/fpd_stencil.sv
module fpd_stencil import fpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [VEL_W-1:0] win_i [WIN_DEPTH],
  input  logic [RATE_W-1:0]       rate_i,
  output st_stat_t                stat_o,
  output logic signed [ACC_W-1:0] res_o
);

  localparam int DIGIT_W     = 4;
  localparam int DIV_DIGITS  = MAG_W / DIGIT_W;
  localparam int CNT_W       = $clog2(DIV_DIGITS);
  localparam int DIVISOR     = 12;
  localparam int ROUND_BIAS  = DIVISOR / 2;
  // floor(v * 171 / 2048) equals floor(v / 12) for every v below 192
  localparam int RECIP       = 171;
  localparam int RECIP_SHIFT = 11;
  localparam int V_W         = 2 * DIGIT_W;
  localparam int PROD_W      = 16;

  st_state_e                state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     neg_q, neg_d;
  logic [DIFF_W-1:0]        dmag_q, dmag_d;
  logic [RATE_W-1:0]        rsh_q, rsh_d;
  logic [MAG_W-1:0]         acc_q, acc_d;
  logic [DIGIT_W-1:0]       rem_q, rem_d;

  logic signed [DIFF_W-1:0] diff;
  logic [V_W-1:0]           v;
  logic [PROD_W-1:0]        prod;
  logic [DIGIT_W-1:0]       qd;
  logic [V_W-1:0]           r8;

  assign diff = DIFF_W'(win_i[0]) - DIFF_W'(win_i[4])
              + ((DIFF_W'(win_i[3]) - DIFF_W'(win_i[1])) <<< 3);

  // one quotient digit of the division by twelve
  assign v    = {rem_q, acc_q[MAG_W-1 -: DIGIT_W]};
  assign prod = PROD_W'(v) * PROD_W'(RECIP);
  assign qd   = prod[RECIP_SHIFT + DIGIT_W - 1 : RECIP_SHIFT];
  assign r8   = v - (V_W'(qd) * V_W'(DIVISOR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dmag_q <= dmag_d;
    rsh_q  <= rsh_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dmag_d  = dmag_q;
    rsh_d   = rsh_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    stat_o  = '{busy: 1'b1, done: 1'b0};
    case (state_q)
      ST_IDLE: begin
        stat_o.busy = 1'b0;
        if (start_i) begin
          neg_d   = diff[DIFF_W-1];
          dmag_d  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
          rsh_d   = rate_i;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // shift-add over the rate bits, most significant first
        acc_d = {acc_q[MAG_W-2:0], 1'b0} + (rsh_q[RATE_W-1] ? MAG_W'(dmag_q) : '0);
        rsh_d = {rsh_q[RATE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RATE_W - 1)) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        acc_d   = acc_q + MAG_W'(ROUND_BIAS);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        acc_d = {acc_q[MAG_W-DIGIT_W-1:0], qd};
        rem_d = r8[DIGIT_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_DIGITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        stat_o.done = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // quotient stays below 2^61, so the signed form cannot wrap
  assign res_o = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

FILE: rtl/core/five_point_derivative_pos_vel_acc_core.sv
// Five-point central-difference core: position, velocity and acceleration
// of one trace.
//
// Input channel: in_valid_i / in_stall_o carry one position beat with an
// end_of_trajectory_i mark. Output channel: out_valid_o / out_stall_i carry
// one aligned (position, velocity, acceleration, last) beat. A beat moves on
// a rising edge with valid high and stall low.
//
// Each accepted sample runs one window advance; the final sample of a trace
// runs four more with itself as end padding. One shared stencil pass runs a
// start step, a shift-add per rate bit for the sample-rate product, a
// rounding step, the radix-16 digits of the divide by twelve and a done
// step. An advance runs a velocity pass and, once five velocities exist,
// an acceleration pass. The input stalls until all advances of the last
// sample are through; results lag four samples behind.
//
// The output register holds one beat; a stalled receiver holds it while the
// core works on, and blocks the core only when a second beat is ready. Reset
// restores the sample rate to 100 Hz; write it via cfg_we_i / cfg_wdata_i idle.
module five_point_derivative_pos_vel_acc_core import fpd_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [RATE_W-1:0]             cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] position_sample_i,
  input  logic                          end_of_trajectory_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] position_out_o,
  output logic signed [VEL_W-1:0]       velocity_out_o,
  output logic signed [ACC_W-1:0]       acceleration_out_o,
  output logic                          last_output_o
);

  fpd_state_e                    state_q, state_d;
  logic [RATE_W-1:0]             rate_q;
  logic [WARM_W-1:0]             warm_q, warm_d;
  logic [PAD_W-1:0]              pad_q, pad_d;
  logic                          last_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic                          out_valid_q;

  logic                          accept;
  logic                          out_load;
  logic                          st_start;
  cell_ctrl_t                    cell_ctrl;
  st_stat_t                      st_stat;
  logic signed [ACC_W-1:0]       st_res;
  logic signed [VEL_W-1:0]       vel_new;
  logic signed [SAMPLE_BITS-1:0] pos_new;

  logic signed [SAMPLE_BITS-1:0] pos_w  [WIN_DEPTH];
  logic signed [VEL_W-1:0]       vel_w  [WIN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] pos_nb [WIN_DEPTH];
  logic signed [VEL_W-1:0]       vel_nb [WIN_DEPTH];
  logic signed [VEL_W-1:0]       st_win [WIN_DEPTH];

  // Fresh sample straight from the port on acceptance, the held copy for padding
  assign pos_new = (state_q == S_IDLE) ? position_sample_i : samp_q;

  // Saturate the stencil result to the velocity width
  always_comb begin
    if (st_res > VEL_MAX) begin
      vel_new = VEL_W'(VEL_MAX);
    end else if (st_res < VEL_MIN) begin
      vel_new = VEL_W'(VEL_MIN);
    end else begin
      vel_new = VEL_W'(st_res);
    end
  end

  // Window chain: index 0 is the oldest tap, new values enter at the top end
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == WIN_DEPTH - 1) begin : g_head
      assign pos_nb[i] = pos_new;
      assign vel_nb[i] = vel_new;
    end else begin : g_link
      assign pos_nb[i] = pos_w[i+1];
      assign vel_nb[i] = vel_w[i+1];
    end

    // Acceleration pass reads velocities, the velocity pass reads positions
    assign st_win[i] = (state_q == S_ACC_GO) ? vel_w[i] : VEL_W'(pos_w[i]);

    fpd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .pos_new_i (pos_new),
      .pos_nb_i  (pos_nb[i]),
      .vel_nb_i  (vel_nb[i]),
      .pos_o     (pos_w[i]),
      .vel_o     (vel_w[i])
    );
  end

  fpd_stencil u_stencil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_start),
    .win_i   (st_win),
    .rate_i  (rate_q),
    .stat_o  (st_stat),
    .res_o   (st_res)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Sequencer: one window advance, then its velocity pass and, once warm, its acceleration pass
  always_comb begin
    state_d   = state_q;
    warm_d    = warm_q;
    pad_d     = pad_q;
    cell_ctrl = '0;
    st_start  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // a new trace fills the whole window with its first sample
          cell_ctrl.fill      = (warm_q == '0);
          cell_ctrl.pos_shift = (warm_q != '0);
          pad_d               = '0;
          state_d             = S_VEL_GO;
        end
      end
      S_VEL_GO: begin
        st_start = 1'b1;
        state_d  = S_VEL_WAIT;
      end
      S_VEL_WAIT: begin
        if (st_stat.done) begin
          cell_ctrl.vel_shift = 1'b1;
          if (warm_q != WARM_W'(WIN_DEPTH)) begin
            warm_d = warm_q + 1'b1;
          end
          state_d = (warm_q >= WARM_W'(WIN_DEPTH - 1)) ? S_ACC_GO : S_NEXT;
        end
      end
      S_ACC_GO: begin
        st_start = 1'b1;
        state_d  = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        if (st_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // the stencil holds its result until the next start
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_q && (pad_q != PAD_W'(PAD_SAMPLES))) begin
          cell_ctrl.pos_shift = 1'b1;
          pad_d               = pad_q + 1'b1;
          state_d             = S_VEL_GO;
        end else begin
          if (last_q) begin
            warm_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= RATE_RESET;
      warm_q      <= '0;
      pad_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      warm_q  <= warm_d;
      pad_q   <= pad_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (accept) begin
        last_q <= end_of_trajectory_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: held sample and the output beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= position_sample_i;
    end
    if (out_load) begin
      position_out_o     <= pos_w[0];
      velocity_out_o     <= vel_w[2];
      acceleration_out_o <= st_res;
      last_output_o      <= last_q && (pad_q == PAD_W'(PAD_SAMPLES));
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_start |-> !st_stat.busy)
    else $error("stencil started while busy");

  a_warm_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_q <= WARM_W'(WIN_DEPTH))
    else $error("warm-up count out of range");

  a_load_warm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (warm_q == WARM_W'(WIN_DEPTH)))
    else $error("result issued before window is full");

  a_trace_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEXT && last_q && pad_q == PAD_W'(PAD_SAMPLES))
      |=> (warm_q == '0 && state_q == S_IDLE))
    else $error("trace end did not restart warm-up");

  a_pad_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q != '0) |-> last_q)
    else $error("end padding without a final sample");

endmodule

FILE: verif/testbench.sv
module testbench;
  import fpd_pkg::*;

  localparam int SAMPLE_BITS = 32;
  localparam logic signed [SAMPLE_BITS-1:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_BITS-1:0] P_MIN = 32'sh8000_0000;
  localparam logic [RATE_W-1:0] RATE_TOP = '1;
  localparam logic [RATE_W-1:0] RATE_SPEC_MAX = 11'd1100;

  // Idle stretch after the last expected beat, with a margin on top.
  localparam int SETTLE_CYCLES = 400;
  // Watchdog limit, well above the slowest legal run.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RX_HOLDOFF = 1500;
  localparam int MAX_REPORTS = 40;

  // Shapes of generated traces.
  typedef enum int {
    SHAPE_SMOOTH,
    SHAPE_NOISE,
    SHAPE_CORNERS,
    SHAPE_TINY
  } trace_shape_e;

  // One output beat: aligned position, velocity, acceleration and last mark.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pos;
    logic signed [VEL_W-1:0]       vel;
    logic signed [ACC_W-1:0]       acc;
    logic                          is_last;
  } kin_beat_t;

  // Tracks the padded position and velocity windows of the current trace and
  // works out the beats each accepted sample must produce.
  class trace_kinematics_sb;
    longint signed    pos_win[WIN_DEPTH];
    longint signed    vel_win[WIN_DEPTH];
    int               warm;
    logic [RATE_W-1:0] rate;
    kin_beat_t        batch[$];
    kin_beat_t        expected_beats[$];
    int               errors;

    function new();
      foreach (pos_win[i]) pos_win[i] = 0;
      foreach (vel_win[i]) vel_win[i] = 0;
      warm = 0;
      rate = RATE_RESET;
      errors = 0;
    endfunction

    function void set_rate(logic [RATE_W-1:0] value);
      rate = value;
    endfunction

    // (w0 - 8*w1 + 8*w3 - w4) * rate / 12, rounded half away from zero.
    function longint signed five_point(longint signed w0, longint signed w1,
                                       longint signed w3, longint signed w4);
      longint signed   d;
      longint signed   x;
      longint unsigned mag;
      longint unsigned q;
      d = w0 - 8 * w1 + 8 * w3 - w4;
      x = d * longint'(rate);
      mag = (x < 0) ? longint'(-x) : longint'(x);
      q = (mag + 64'd6) / 64'd12;
      return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint signed clamp_vel(longint signed v);
      if (v > VEL_MAX) return VEL_MAX;
      if (v < VEL_MIN) return VEL_MIN;
      return v;
    endfunction

    // Shift one padded position in; once five velocities exist, emit a beat.
    function void push_position(longint signed p);
      kin_beat_t b;
      for (int i = 0; i < WIN_DEPTH - 1; i++) pos_win[i] = pos_win[i + 1];
      pos_win[WIN_DEPTH - 1] = p;
      for (int i = 0; i < WIN_DEPTH - 1; i++) vel_win[i] = vel_win[i + 1];
      vel_win[WIN_DEPTH - 1] = clamp_vel(five_point(pos_win[0], pos_win[1],
                                                    pos_win[3], pos_win[4]));
      if (warm < WIN_DEPTH) warm++;
      if (warm >= WIN_DEPTH && batch.size() < WIN_DEPTH) begin
        b.pos = pos_win[0][SAMPLE_BITS-1:0];
        b.vel = vel_win[2][VEL_W-1:0];
        b.acc = five_point(vel_win[0], vel_win[1], vel_win[3], vel_win[4]);
        b.is_last = 1'b0;
        batch = {batch, b};
      end
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] sample, logic eot);
      longint signed p;
      p = sample;
      batch.delete();
      // A new trace starts padded with copies of its first sample.
      if (warm == 0) foreach (pos_win[i]) pos_win[i] = p;
      push_position(p);
      if (eot) begin
        repeat (PAD_SAMPLES) push_position(p);
        if (batch.size() > 0) batch[batch.size() - 1].is_last = 1'b1;
        warm = 0;
      end
      foreach (batch[i]) expected_beats = {expected_beats, batch[i]};
    endfunction

    function void report(string what, longint signed want, longint signed got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_beat(kin_beat_t got);
      kin_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat: expected none, actual pos %0d vel %0d acc %0d",
                   $time, got.pos, got.vel, got.acc);
        return;
      end
      want = expected_beats.pop_front();
      if (got.pos !== want.pos) report("position", want.pos, got.pos);
      if (got.vel !== want.vel) report("velocity", want.vel, got.vel);
      if (got.acc !== want.acc) report("acceleration", want.acc, got.acc);
      if (got.is_last !== want.is_last) report("last mark", want.is_last, got.is_last);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [RATE_W-1:0]             cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] position_sample_i;
  logic                          end_of_trajectory_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SAMPLE_BITS-1:0] position_out_o;
  logic signed [VEL_W-1:0]       velocity_out_o;
  logic signed [ACC_W-1:0]       acceleration_out_o;
  logic                          last_output_o;

  trace_kinematics_sb sb = new();

  logic signed [SAMPLE_BITS-1:0] trace_q[$];
  int samples_sent = 0;
  int tx_run_left = 0;
  int hold_req = 0;     // receiver hold-off request, taken up by the sink
  bit quiet = 1'b0;     // no idling on either side once set

  five_point_derivative_pos_vel_acc_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .position_sample_i   (position_sample_i),
    .end_of_trajectory_i (end_of_trajectory_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .position_out_o      (position_out_o),
    .velocity_out_o      (velocity_out_o),
    .acceleration_out_o  (acceleration_out_o),
    .last_output_o       (last_output_o)
  );

  always #10 clk_i = ~clk_i;

  // Append one sample to the trace being built.
  function automatic void append_sample(logic signed [SAMPLE_BITS-1:0] s);
    trace_q = {trace_q, s};
  endfunction

  // Offer one sample and hold it until the core takes the beat.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample, logic eot);
    in_valid_i          <= 1'b1;
    position_sample_i   <= sample;
    end_of_trajectory_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(sample, eot);
    samples_sent++;
  endtask

  // Drop valid for a random burst now and then; runs of back-to-back beats between.
  task automatic sender_gap();
    int n;
    if (quiet) return;
    if (tx_run_left > 0) begin
      tx_run_left--;
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end else begin
      tx_run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
  endtask

  // Send trace_q as one trace, marking its last sample.
  task automatic send_trace();
    foreach (trace_q[i]) begin
      send_sample(trace_q[i], i == trace_q.size() - 1);
      sender_gap();
    end
  endtask

  // Fill trace_q with a trace of random length and shape.
  task automatic make_trace();
    int                            len;
    int                            pick;
    trace_shape_e                  shape;
    logic signed [SAMPLE_BITS-1:0] base;
    logic signed [SAMPLE_BITS-1:0] slope;
    logic signed [SAMPLE_BITS-1:0] curve;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    shape = (pick < 5) ? SHAPE_SMOOTH : (pick < 7) ? SHAPE_NOISE :
            (pick < 9) ? SHAPE_CORNERS : SHAPE_TINY;
    base  = $urandom;
    slope = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    curve = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
    trace_q.delete();
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_SMOOTH: append_sample(base + slope * i + curve * i * i);
        SHAPE_NOISE:  append_sample($urandom);
        SHAPE_CORNERS: begin
          case ($urandom_range(0, 4))
            0: append_sample(P_MAX);
            1: append_sample(P_MIN);
            2: append_sample('0);
            3: append_sample('1);
            default: append_sample(1);
          endcase
        end
        default: append_sample($signed($urandom_range(0, 64)) - 32);
      endcase
    end
  endtask

  // Keep sending random traces until this phase has moved the given number of beats.
  task automatic random_phase(int quota);
    int start;
    start = samples_sent;
    while (samples_sent - start < quota) begin
      make_trace();
      send_trace();
    end
  endtask

  // Hold off the sender until every expected beat is back, then let the core settle.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the sample rate; only called with the core idle.
  task automatic write_rate(logic [RATE_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_rate(value);
  endtask

  // Result sink: check every beat taken, and drive stall in bursts.
  initial begin : result_sink
    kin_beat_t seen;
    int stall_left;
    int run_left;
    int hold_left;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen.pos     = position_out_o;
        seen.vel     = velocity_out_o;
        seen.acc     = acceleration_out_o;
        seen.is_last = last_output_o;
        sb.check_beat(seen);
      end
      // A hold-off request freezes the output for a long stretch, counted here.
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 13);
          else run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(1, 20);
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          run_left--;
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Watchdog: report a failure and end the run once it reaches the overall time limit.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_valid_i          <= 1'b0;
    position_sample_i   <= '0;
    end_of_trajectory_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed traces at the reset rate: one, two, three and four samples,
    // each shorter than the window, then a full trace swinging between extremes.
    trace_q = {P_MAX};
    send_trace();
    trace_q = {P_MIN, P_MAX};
    send_trace();
    trace_q = {32'sd0, -32'sd1, 32'sd1};
    send_trace();
    trace_q = {P_MAX, P_MIN, P_MAX, P_MIN};
    send_trace();
    trace_q = {P_MIN, P_MAX, P_MIN, P_MAX, P_MIN, P_MAX, P_MIN};
    send_trace();
    drain_and_settle();

    // Largest rate the register holds with the widest swings: biggest derivatives.
    write_rate(RATE_TOP);
    trace_q = {P_MAX, P_MIN, P_MAX, P_MIN, P_MAX, P_MIN};
    send_trace();
    drain_and_settle();

    // Zero rate: every derivative must come out zero.
    write_rate('0);
    random_phase(30);
    drain_and_settle();

    write_rate(11'd1);
    random_phase(50);
    drain_and_settle();

    // Hold the output for a long stretch while samples keep coming, so the
    // core fills up and stalls its input.
    write_rate(RATE_SPEC_MAX);
    hold_req = RX_HOLDOFF;
    random_phase(50);
    drain_and_settle();

    write_rate(RATE_W'($urandom_range(2, 1099)));
    random_phase(50);
    drain_and_settle();

    write_rate(RATE_W'($urandom_range(0, 2047)));
    random_phase(50);
    drain_and_settle();

    // Last stretch runs flat out on both sides.
    write_rate(RATE_W'($urandom_range(1, 1100)));
    quiet = 1'b1;
    random_phase(40);
    drain_and_settle();

    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
